/* rtl/fra_pkg.sv */
`default_nettype none
package fra_pkg;
  localparam int unsigned TableEntries = 64;
  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned PageShift = 12;

  typedef logic [1:0] status_t;
  localparam status_t StOk      = 2'd0;
  localparam status_t StNoFit   = 2'd1;
  localparam status_t StOverlap = 2'd2;
  localparam status_t StFull    = 2'd3;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StWait,
    StDecide,
    StUpdate,
    StFinish
  } state_e;
endpackage
`default_nettype wire

/* rtl/free_range_allocator.sv */
`default_nettype none
// Free range allocator: best-fit table of free page ranges with merging.
// Pulse start_i with command_i and its operands while busy_o is low; the
// command is taken on that edge and busy_o rises on the next cycle.
// Acquire (command 0) rounds request_size_i up to 4 KiB pages and takes the
// exact-size entry or else the smallest larger one, carving from its start.
// Release (command 1) page-aligns release_begin_i/release_end_i, rejects an
// overlap with a free entry, and merges with touching neighbours or takes
// the lowest empty slot.
// Each command gives one result: status_o, granted_begin_o, granted_end_o,
// shown for exactly one cycle with done_o high. The receiver cannot stall.
// The scan reads one table entry per cycle from the table memory in StScan
// until all TableEntries entries are read, then runs StWait, StDecide,
// StUpdate and StFinish; done_o is registered from StFinish. busy_o stays
// high until done_o rises, so a new command waits for the last result. Size
// zero, oversized acquires and empty releases skip the scan and StWait.
// One 64-bit adder/comparator set is shared across the scan.
// Reset empties the table at once through per-entry valid flip-flops.
module free_range_allocator
  import fra_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic        command_i,
  input  wire logic [63:0] request_size_i,
  input  wire logic [63:0] release_begin_i,
  input  wire logic [63:0] release_end_i,
  output logic             done_o,
  output logic [1:0]       status_o,
  output logic [63:0]      granted_begin_o,
  output logic [63:0]      granted_end_o
);

  localparam logic [63:0] PageMask = 64'((64'd1 << PageShift) - 64'd1);
  localparam logic [63:0] Top      = ~PageMask;

  logic [63:0] base_mem [TableEntries];
  logic [63:0] len_mem  [TableEntries];
  logic [TableEntries-1:0] valid_q, valid_d;

  state_e state_q, state_d;
  logic        cmd_q, cmd_d;
  logic [63:0] b_q, b_d, e_q, e_d;
  logic        triv_q, triv_d, nofit_q, nofit_d;
  logic [IdxW:0] idx_q, idx_d;
  logic [IdxW-1:0] rd_idx_q;
  logic        rd_vld_q, rd_vld_d;
  logic [63:0] rd_base_q, rd_len_q;
  logic        exact_f_q, exact_f_d, best_f_q, best_f_d;
  logic        prev_f_q, prev_f_d, next_f_q, next_f_d, slot_f_q, slot_f_d, ovl_q, ovl_d;
  logic [IdxW-1:0] exact_i_q, exact_i_d, best_i_q, best_i_d;
  logic [IdxW-1:0] prev_i_q, prev_i_d, next_i_q, next_i_d, slot_i_q, slot_i_d;
  logic [63:0] best_len_q, best_len_d, exact_base_q, exact_base_d;
  logic [63:0] best_base_q, best_base_d, prev_len_q, prev_len_d, next_len_q, next_len_d;
  logic        done_q, done_d;
  logic [1:0]  st_q, st_d;
  logic [63:0] gb_q, gb_d, ge_q, ge_d;

  logic          we;
  logic [IdxW-1:0] wa;
  logic [63:0]   wbase, wlen;
  logic          we2;
  logic [IdxW-1:0] wa2;
  logic [63:0]   wbase2, wlen2;

  logic [63:0] ee, need;
  logic [64:0] pg_round;
  logic [52:0] pages;

  assign ee = rd_base_q + rd_len_q;
  assign pages = {1'b0, request_size_i[63:PageShift]} +
                 53'(request_size_i[PageShift-1:0] != '0);
  assign pg_round = 65'(pages) << PageShift;
  assign need = e_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      base_mem[wa] <= wbase;
      len_mem[wa]  <= wlen;
    end
    if (we2) begin
      base_mem[wa2] <= wbase2;
      len_mem[wa2]  <= wlen2;
    end
    rd_base_q <= base_mem[idx_q[IdxW-1:0]];
    rd_len_q  <= len_mem[idx_q[IdxW-1:0]];
    rd_idx_q  <= idx_q[IdxW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_q <= '0;
      done_q  <= 1'b0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      done_q  <= done_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; b_q <= b_d; e_q <= e_d; triv_q <= triv_d; nofit_q <= nofit_d;
    idx_q <= idx_d;
    exact_f_q <= exact_f_d; best_f_q <= best_f_d; prev_f_q <= prev_f_d;
    next_f_q <= next_f_d; slot_f_q <= slot_f_d; ovl_q <= ovl_d;
    exact_i_q <= exact_i_d; best_i_q <= best_i_d; prev_i_q <= prev_i_d;
    next_i_q <= next_i_d; slot_i_q <= slot_i_d;
    best_len_q <= best_len_d; exact_base_q <= exact_base_d; best_base_q <= best_base_d;
    prev_len_q <= prev_len_d; next_len_q <= next_len_d;
    st_q <= st_d; gb_q <= gb_d; ge_q <= ge_d;
  end

  always_comb begin
    state_d = state_q; valid_d = valid_q;
    cmd_d = cmd_q; b_d = b_q; e_d = e_q; triv_d = triv_q; nofit_d = nofit_q;
    idx_d = idx_q; rd_vld_d = 1'b0;
    exact_f_d = exact_f_q; best_f_d = best_f_q; prev_f_d = prev_f_q;
    next_f_d = next_f_q; slot_f_d = slot_f_q; ovl_d = ovl_q;
    exact_i_d = exact_i_q; best_i_d = best_i_q; prev_i_d = prev_i_q;
    next_i_d = next_i_q; slot_i_d = slot_i_q;
    best_len_d = best_len_q; exact_base_d = exact_base_q; best_base_d = best_base_q;
    prev_len_d = prev_len_q; next_len_d = next_len_q;
    done_d = 1'b0; st_d = st_q; gb_d = gb_q; ge_d = ge_q;
    we = 1'b0; wa = '0; wbase = '0; wlen = '0;
    we2 = 1'b0; wa2 = '0; wbase2 = '0; wlen2 = '0;

    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_d = command_i;
          idx_d = '0;
          exact_f_d = 1'b0; best_f_d = 1'b0; prev_f_d = 1'b0;
          next_f_d = 1'b0; slot_f_d = 1'b0; ovl_d = 1'b0;
          nofit_d = 1'b0;
          if (!command_i) begin
            triv_d  = (request_size_i == '0);
            nofit_d = pg_round[64];
            e_d     = pg_round[63:0];
            b_d     = '0;
          end else begin
            b_d = release_begin_i & ~PageMask;
            if (release_end_i > Top) begin
              e_d = Top;
            end else begin
              e_d = (release_end_i + PageMask) & ~PageMask;
            end
            triv_d = (release_begin_i == release_end_i);
          end
          state_d = StScan;
        end
      end
      StScan: begin
        if (cmd_q == 1'b1 && e_q <= b_q) triv_d = 1'b1;
        if (triv_q || nofit_q || (cmd_q == 1'b1 && e_q <= b_q)) begin
          state_d = StDecide;
        end else begin
          rd_vld_d = 1'b1;
          idx_d = idx_q + 1'b1;
          if (idx_q == (IdxW+1)'(TableEntries - 1)) state_d = StWait;
        end
      end
      StWait: state_d = StDecide;
      StDecide: state_d = StUpdate;
      StUpdate: begin
        st_d = StOk; gb_d = '0; ge_d = '0;
        if (triv_q) begin
          st_d = StOk;
        end else if (!cmd_q) begin
          if (nofit_q) begin
            st_d = StNoFit;
          end else if (exact_f_q) begin
            gb_d = exact_base_q; ge_d = exact_base_q + need;
            valid_d[exact_i_q] = 1'b0;
            we = 1'b1; wa = exact_i_q;
          end else if (best_f_q) begin
            gb_d = best_base_q; ge_d = best_base_q + need;
            we = 1'b1; wa = best_i_q;
            wbase = best_base_q + need; wlen = best_len_q - need;
          end else begin
            st_d = StNoFit;
          end
        end else begin
          if (ovl_q) begin
            st_d = StOverlap;
          end else if (prev_f_q && next_f_q) begin
            we = 1'b1; wa = prev_i_q;
            wbase = b_q - prev_len_q;
            wlen = prev_len_q + (e_q - b_q) + next_len_q;
            we2 = 1'b1; wa2 = next_i_q;
            valid_d[next_i_q] = 1'b0;
          end else if (prev_f_q) begin
            we = 1'b1; wa = prev_i_q;
            wbase = b_q - prev_len_q; wlen = prev_len_q + (e_q - b_q);
          end else if (next_f_q) begin
            we = 1'b1; wa = next_i_q;
            wbase = b_q; wlen = next_len_q + (e_q - b_q);
          end else if (slot_f_q) begin
            we = 1'b1; wa = slot_i_q; wbase = b_q; wlen = e_q - b_q;
            valid_d[slot_i_q] = 1'b1;
          end else begin
            st_d = StFull;
          end
        end
        state_d = StFinish;
      end
      StFinish: begin
        done_d = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase

    if (rd_vld_q) begin
      if (!valid_q[rd_idx_q]) begin
        if (!slot_f_d) begin
          slot_f_d = 1'b1; slot_i_d = rd_idx_q;
        end
      end else if (!cmd_q) begin
        if (rd_len_q == need) begin
          if (!exact_f_d) begin
            exact_f_d = 1'b1; exact_i_d = rd_idx_q; exact_base_d = rd_base_q;
          end
        end else if (rd_len_q > need) begin
          if (!best_f_d || rd_len_q < best_len_q) begin
            best_f_d = 1'b1; best_i_d = rd_idx_q;
            best_len_d = rd_len_q; best_base_d = rd_base_q;
          end
        end
      end else begin
        if (rd_base_q < e_q && b_q < ee) ovl_d = 1'b1;
        if (ee == b_q && !prev_f_d) begin
          prev_f_d = 1'b1; prev_i_d = rd_idx_q; prev_len_d = rd_len_q;
        end
        if (rd_base_q == e_q && !next_f_d) begin
          next_f_d = 1'b1; next_i_d = rd_idx_q; next_len_d = rd_len_q;
        end
      end
    end
  end

  assign busy_o = (state_q != StIdle);
  assign done_o = done_q;
  assign status_o = st_q;
  assign granted_begin_o = gb_q;
  assign granted_end_o = ge_q;

endmodule
`default_nettype wire

/* dv/tb_top.sv */
module tb_top;
  import fra_pkg::*;

  localparam logic CmdAcquire = 1'b0;
  localparam logic CmdRelease = 1'b1;
  localparam logic [63:0] PageBytes = 64'd4096;
  localparam int unsigned NumItems = 800;

  typedef struct {
    logic        cmd;
    logic [63:0] size;
    logic [63:0] rel_begin;
    logic [63:0] rel_end;
    bit          drain;
  } alloc_cmd_t;

  typedef struct {
    status_t     status;
    logic [63:0] gbegin;
    logic [63:0] gend;
  } alloc_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        command_i = CmdAcquire;
  logic [63:0] request_size_i = '0;
  logic [63:0] release_begin_i = '0;
  logic [63:0] release_end_i = '0;
  logic        busy_o;
  logic        done_o;
  logic [1:0]  status_o;
  logic [63:0] granted_begin_o;
  logic [63:0] granted_end_o;

  alloc_cmd_t    cmd_q[$];
  alloc_result_t grant_q[$];

  logic [63:0] free_base[TableEntries];
  logic [63:0] free_len[TableEntries];
  bit          free_valid[TableEntries];

  int unsigned errors = 0;
  int unsigned n_acq = 0;
  int unsigned n_rel = 0;
  int unsigned status_seen[4] = '{0, 0, 0, 0};

  free_range_allocator dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic alloc_result_t acquire_range(logic [63:0] size);
    alloc_result_t r;
    logic [63:0] pages, need;
    int exact, best;
    r = '{StOk, 64'd0, 64'd0};
    exact = -1;
    best = -1;
    if (size == 0) return r;
    pages = (size >> PageShift) + ((size[PageShift-1:0] != 0) ? 64'd1 : 64'd0);
    if (pages > (64'hffff_ffff_ffff_ffff / PageBytes)) begin
      r.status = StNoFit;
      return r;
    end
    need = pages * PageBytes;
    for (int i = 0; i < TableEntries; i++) begin
      if (!free_valid[i]) continue;
      if (free_len[i] == need) begin
        if (exact < 0) exact = i;
      end else if (free_len[i] > need) begin
        if (best < 0 || free_len[i] < free_len[best]) best = i;
      end
    end
    if (exact >= 0) begin
      r.gbegin = free_base[exact];
      r.gend = free_base[exact] + need;
      free_valid[exact] = 0;
      free_base[exact] = 0;
      free_len[exact] = 0;
    end else if (best < 0) begin
      r.status = StNoFit;
    end else begin
      r.gbegin = free_base[best];
      r.gend = free_base[best] + need;
      free_base[best] += need;
      free_len[best] -= need;
    end
    return r;
  endfunction

  function automatic alloc_result_t release_range(logic [63:0] rb, logic [63:0] re);
    alloc_result_t r;
    logic [63:0] b, e, len, top, eb, ee;
    int prv, nxt, slot;
    r = '{StOk, 64'd0, 64'd0};
    prv = -1;
    nxt = -1;
    slot = -1;
    if (rb == re) return r;
    b = rb & ~(PageBytes - 1);
    top = 64'hffff_ffff_ffff_f000;
    if (re > top) e = top;
    else e = (re + PageBytes - 1) & ~(PageBytes - 1);
    if (e <= b) return r;
    len = e - b;
    for (int i = 0; i < TableEntries; i++) begin
      if (!free_valid[i]) begin
        if (slot < 0) slot = i;
        continue;
      end
      eb = free_base[i];
      ee = eb + free_len[i];
      if (eb < e && b < ee) begin
        r.status = StOverlap;
        return r;
      end
      if (ee == b && prv < 0) prv = i;
      if (eb == e && nxt < 0) nxt = i;
    end
    if (prv >= 0 && nxt >= 0) begin
      free_len[prv] += len + free_len[nxt];
      free_valid[nxt] = 0;
      free_base[nxt] = 0;
      free_len[nxt] = 0;
    end else if (prv >= 0) begin
      free_len[prv] += len;
    end else if (nxt >= 0) begin
      free_base[nxt] = b;
      free_len[nxt] += len;
    end else if (slot >= 0) begin
      free_valid[slot] = 1;
      free_base[slot] = b;
      free_len[slot] = len;
    end else begin
      r.status = StFull;
    end
    return r;
  endfunction

  function automatic alloc_result_t predict_grant(alloc_cmd_t c);
    if (c.cmd == CmdAcquire) return acquire_range(c.size);
    return release_range(c.rel_begin, c.rel_end);
  endfunction

  task automatic add_acq(logic [63:0] size);
    cmd_q.push_back('{CmdAcquire, size, {$urandom, $urandom}, {$urandom, $urandom}, 1'b0});
  endtask

  task automatic add_rel(logic [63:0] b, logic [63:0] e);
    cmd_q.push_back('{CmdRelease, {$urandom, $urandom}, b, e, 1'b0});
  endtask

  // driver
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  always @(posedge clk_i) begin
    bit go;
    alloc_cmd_t c;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        c = cmd_q.pop_front();
        grant_q.push_back(predict_grant(c));
        if (c.cmd == CmdAcquire) n_acq++;
        else n_rel++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end
      end
      if (!(start_i && busy_o)) begin
        go = 0;
        if (cmd_q.size() == 0) go = 0;
        else if (cmd_q[0].drain && grant_q.size() != 0) go = 0;
        else if (gap_left > 0) gap_left--;
        else go = 1;
        start_i <= go;
        if (go) begin
          command_i <= cmd_q[0].cmd;
          request_size_i <= cmd_q[0].size;
          release_begin_i <= cmd_q[0].rel_begin;
          release_end_i <= cmd_q[0].rel_end;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    alloc_result_t x;
    if (rst_ni && done_o) begin
      status_seen[status_o]++;
      if (grant_q.size() == 0) begin
        $error("unexpected result: status %0d", status_o);
        errors++;
      end else begin
        x = grant_q.pop_front();
        if (status_o !== x.status) begin
          $error("status: expected %0d, got %0d", x.status, status_o);
          errors++;
        end
        if (granted_begin_o !== x.gbegin) begin
          $error("granted_begin: expected %h, got %h", x.gbegin, granted_begin_o);
          errors++;
        end
        if (granted_end_o !== x.gend) begin
          $error("granted_end: expected %h, got %h", x.gend, granted_end_o);
          errors++;
        end
      end
    end
  end

  initial begin
    #50_000_000;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [63:0] b;
    int unsigned sel, fills;
    for (int i = 0; i < TableEntries; i++) begin
      free_base[i] = 0;
      free_len[i] = 0;
      free_valid[i] = 0;
    end
    add_acq(64'd4096);
    add_acq(64'd0);
    add_rel(64'd5000, 64'd5000);
    add_rel(64'h1001, 64'h1000);
    add_rel(64'h10000, 64'h20000);
    add_rel(64'h20000, 64'h22001);
    add_rel(64'hE000, 64'h10000);
    add_rel(64'h30000, 64'h31000);
    add_rel(64'h23000, 64'h30000);
    add_rel(64'h10000, 64'h11000);
    add_rel(64'hffff_ffff_ffff_0000, 64'hffff_ffff_ffff_ffff);
    add_acq(64'hffff_ffff_ffff_ffff);
    add_acq(64'hffff_ffff_ffff_f001);
    add_rel(64'h40000, 64'h41000);
    add_rel(64'h50000, 64'h51000);
    add_acq(64'd1);
    add_acq(64'h1001);
    add_acq(64'h23000);
    add_acq(64'hf000);
    add_rel(64'h0, 64'h1);
    fills = 0;
    while (cmd_q.size() < NumItems) begin
      if (cmd_q.size() >= NumItems / 2 && cmd_q.size() < NumItems / 2 + 5)
        add_acq(64'h2000);
      sel = $urandom_range(0, 99);
      if (sel < 2 && fills < 2) begin
        fills++;
        for (int k = 0; k < TableEntries + 4; k++)
          add_rel(64'h1000_0000 + k * 64'h2000, 64'h1000_0000 + k * 64'h2000 + 64'hfff);
        for (int k = 0; k < TableEntries + 4; k++) add_acq($urandom_range(1, 4096));
      end else if (sel < 10) begin
        if ($urandom_range(0, 1)) add_acq({$urandom, $urandom});
        else add_rel({$urandom, $urandom}, {$urandom, $urandom});
      end else if (sel < 55) begin
        b = $urandom_range(0, 255) * PageBytes + $urandom_range(0, 1) * $urandom_range(0, 4095);
        add_rel(b, b + $urandom_range(1, 8) * PageBytes - $urandom_range(0, 4095));
      end else begin
        add_acq($urandom_range(0, 8 * 4096));
      end
    end
    cmd_q[NumItems / 2].drain = 1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i); while (cmd_q.size() != 0 || start_i || grant_q.size() != 0);
    repeat (200) @(posedge clk_i);
    if (grant_q.size() != 0) begin
      $error("%0d results never arrived", grant_q.size());
      errors++;
    end
    $display("covered %0d acquires and %0d releases", n_acq, n_rel);
    $display("results ok/nofit/overlap/full: %0d/%0d/%0d/%0d",
             status_seen[StOk], status_seen[StNoFit], status_seen[StOverlap],
             status_seen[StFull]);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
